// ----- rtl/ccu_pkg.sv -----
`default_nettype none

package ccu_pkg;

  // coordinate and fraction sizes
  localparam int CB = 16;
  localparam int FB = 8;

  // stream word sizes
  localparam int IN_W  = 6 * CB;
  localparam int OW    = 32;
  localparam int OUT_W = 3 * OW;
  localparam int USR_W = 2;

  // out_tuser bit positions
  localparam int USR_COLL = 0;
  localparam int USR_SAT  = 1;

  // arithmetic widths
  localparam int DW   = CB + 1;          // coordinate differences
  localparam int SQW  = 2 * CB;          // squares
  localparam int KW   = 2 * CB + 2;      // bisector offsets
  localparam int MW   = 2 * DW;          // determinant products
  localparam int DETW = 2 * DW + 1;      // determinant
  localparam int PW   = DW + KW;         // numerator products
  localparam int NW   = PW + 1;          // numerators
  localparam int DVDW = NW + FB + 2;     // scaled, rounded dividend
  localparam int DVW  = DETW + 2;        // divisor, four times |det|
  localparam int QB   = 41;              // quotient bits kept
  localparam int HIW  = DVDW - QB;       // dividend bits above the quotient
  localparam int CW   = QB + 2;          // center minus point, signed
  localparam int RW   = 64;              // square root operand
  localparam int SQN  = RW / 2;          // root steps

  typedef struct packed {
    logic [DVW-1:0]         rem_x;
    logic [DVW-1:0]         rem_y;
    logic [QB-1:0]          dq_x;
    logic [QB-1:0]          dq_y;
    logic [DVW-1:0]         dv;
    logic                   ovf_x;
    logic                   ovf_y;
    logic                   neg_x;
    logic                   neg_y;
    logic                   coll;
    logic signed [CB-1:0]   ax;
    logic signed [CB-1:0]   ay;
  } div_t;

  typedef struct packed {
    logic [RW-1:0] v;
    logic [RW-1:0] r;
    logic [OW-1:0] cx;
    logic [OW-1:0] cy;
    logic          satc;
    logic          coll;
    logic          rsat;
  } sqrt_t;

endpackage

`default_nettype wire

// ----- rtl/circumcircle_from_three_points_unit.sv -----
// Throughput: one word per cycle; the whole pipeline advances when the output register
// is empty or being taken, so in_tready follows out_tready combinationally.
// Depth is set by the two 41-step restoring dividers and the 32-step square root.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are not reset.
`default_nettype none

module circumcircle_from_three_points_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [ccu_pkg::IN_W-1:0]    in_tdata,   // ax, ay, bx, by, cx, cy
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [ccu_pkg::OUT_W-1:0]        out_tdata,  // center_x, center_y, radius
  output logic [ccu_pkg::USR_W-1:0]        out_tuser   // collinear, saturated
);
  import ccu_pkg::*;

  localparam logic [QB-1:0] POS_MAX = QB'(32'h7FFF_FFFF);
  localparam logic [QB-1:0] NEG_MAX = QB'(32'h8000_0000);

  logic adv;

  logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;

  assign in_ax = in_tdata[0*CB +: CB];
  assign in_ay = in_tdata[1*CB +: CB];
  assign in_bx = in_tdata[2*CB +: CB];
  assign in_by = in_tdata[3*CB +: CB];
  assign in_cx = in_tdata[4*CB +: CB];
  assign in_cy = in_tdata[5*CB +: CB];

  // advance everything when the output register is free or being taken
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- stage 1: differences and squares
  logic                 s1_v_r;
  logic signed [CB-1:0] s1_ax_r, s1_ay_r;
  logic signed [DW-1:0] s1_dx1_r, s1_dy1_r, s1_dx2_r, s1_dy2_r;
  logic [SQW-1:0]       s1_sax_r, s1_say_r, s1_sbx_r, s1_sby_r, s1_scx_r, s1_scy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax_r  <= in_ax;
      s1_ay_r  <= in_ay;
      s1_dx1_r <= DW'(in_bx) - DW'(in_ax);
      s1_dy1_r <= DW'(in_by) - DW'(in_ay);
      s1_dx2_r <= DW'(in_cx) - DW'(in_bx);
      s1_dy2_r <= DW'(in_cy) - DW'(in_by);
      s1_sax_r <= SQW'(in_ax * in_ax);
      s1_say_r <= SQW'(in_ay * in_ay);
      s1_sbx_r <= SQW'(in_bx * in_bx);
      s1_sby_r <= SQW'(in_by * in_by);
      s1_scx_r <= SQW'(in_cx * in_cx);
      s1_scy_r <= SQW'(in_cy * in_cy);
    end
  end

  // ---------------- stage 2: bisector offsets and determinant products
  logic                 s2_v_r;
  logic signed [CB-1:0] s2_ax_r, s2_ay_r;
  logic signed [DW-1:0] s2_dx1_r, s2_dy1_r, s2_dx2_r, s2_dy2_r;
  logic signed [KW-1:0] s2_k1_r, s2_k2_r;
  logic signed [MW-1:0] s2_m1_r, s2_m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_dx1_r <= s1_dx1_r;
      s2_dy1_r <= s1_dy1_r;
      s2_dx2_r <= s1_dx2_r;
      s2_dy2_r <= s1_dy2_r;
      s2_k1_r  <= KW'(s1_sbx_r) - KW'(s1_sax_r) + KW'(s1_sby_r) - KW'(s1_say_r);
      s2_k2_r  <= KW'(s1_scx_r) - KW'(s1_sbx_r) + KW'(s1_scy_r) - KW'(s1_sby_r);
      s2_m1_r  <= MW'(s1_dx1_r) * MW'(s1_dy2_r);
      s2_m2_r  <= MW'(s1_dx2_r) * MW'(s1_dy1_r);
    end
  end

  // ---------------- stage 3: determinant and numerator products
  logic                   s3_v_r;
  logic signed [CB-1:0]   s3_ax_r, s3_ay_r;
  logic signed [DETW-1:0] s3_det_r;
  logic signed [PW-1:0]   s3_pa_r, s3_pb_r, s3_pc_r, s3_pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
      s3_det_r <= DETW'(s2_m1_r) - DETW'(s2_m2_r);
      s3_pa_r  <= PW'(s2_dy2_r) * PW'(s2_k1_r);
      s3_pb_r  <= PW'(s2_dy1_r) * PW'(s2_k2_r);
      s3_pc_r  <= PW'(s2_dx1_r) * PW'(s2_k2_r);
      s3_pd_r  <= PW'(s2_dx2_r) * PW'(s2_k1_r);
    end
  end

  // ---------------- stage 4: numerators, |det|
  logic                 s4_v_r;
  logic signed [CB-1:0] s4_ax_r, s4_ay_r;
  logic signed [NW-1:0] s4_nx_r, s4_ny_r;
  logic [DETW-1:0]      s4_adet_r;
  logic                 s4_dneg_r, s4_coll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ax_r   <= s3_ax_r;
      s4_ay_r   <= s3_ay_r;
      s4_nx_r   <= NW'(s3_pa_r) - NW'(s3_pb_r);
      s4_ny_r   <= NW'(s3_pc_r) - NW'(s3_pd_r);
      s4_adet_r <= s3_det_r[DETW-1] ? DETW'(-s3_det_r) : DETW'(s3_det_r);
      s4_dneg_r <= s3_det_r[DETW-1];
      s4_coll_r <= (s3_det_r == '0);
    end
  end

  // ---------------- stage 5: scaled dividends with the rounding half added
  logic                 s5_v_r;
  logic signed [CB-1:0] s5_ax_r, s5_ay_r;
  logic [DVDW-1:0]      s5_dvx_r, s5_dvy_r;
  logic [DVW-1:0]       s5_dv_r;
  logic                 s5_negx_r, s5_negy_r, s5_coll_r;
  logic [NW-1:0]        magx, magy;

  assign magx = s4_nx_r[NW-1] ? NW'(-s4_nx_r) : NW'(s4_nx_r);
  assign magy = s4_ny_r[NW-1] ? NW'(-s4_ny_r) : NW'(s4_ny_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ax_r   <= s4_ax_r;
      s5_ay_r   <= s4_ay_r;
      s5_dvx_r  <= (DVDW'(magx) << (FB + 1)) + DVDW'({s4_adet_r, 1'b0});
      s5_dvy_r  <= (DVDW'(magy) << (FB + 1)) + DVDW'({s4_adet_r, 1'b0});
      s5_dv_r   <= {s4_adet_r, 2'b00};
      s5_negx_r <= s4_nx_r[NW-1] ^ s4_dneg_r;
      s5_negy_r <= s4_ny_r[NW-1] ^ s4_dneg_r;
      s5_coll_r <= s4_coll_r;
    end
  end

  // ---------------- dividers: overflow check, then one quotient bit per stage
  div_t             div_r [0:QB];
  logic [QB:0]      dvv_r;
  div_t             div_init;
  logic [HIW-1:0]   hi_x, hi_y;

  always_comb begin
    hi_x             = s5_dvx_r[DVDW-1:QB];
    hi_y             = s5_dvy_r[DVDW-1:QB];
    div_init.rem_x   = DVW'(hi_x);
    div_init.rem_y   = DVW'(hi_y);
    div_init.dq_x    = s5_dvx_r[QB-1:0];
    div_init.dq_y    = s5_dvy_r[QB-1:0];
    div_init.dv      = s5_dv_r;
    div_init.ovf_x   = (DVW'(hi_x) >= s5_dv_r);
    div_init.ovf_y   = (DVW'(hi_y) >= s5_dv_r);
    div_init.neg_x   = s5_negx_r;
    div_init.neg_y   = s5_negy_r;
    div_init.coll    = s5_coll_r;
    div_init.ax      = s5_ax_r;
    div_init.ay      = s5_ay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r <= '0;
    end else if (adv) begin
      dvv_r <= {dvv_r[QB-1:0], s5_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= div_init;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    logic [DVW:0] tx, ty;
    div_t         div_nxt;

    always_comb begin
      div_nxt      = div_r[g];
      tx           = {div_r[g].rem_x, div_r[g].dq_x[QB-1]};
      ty           = {div_r[g].rem_y, div_r[g].dq_y[QB-1]};
      div_nxt.dq_x = {div_r[g].dq_x[QB-2:0], 1'b0};
      div_nxt.dq_y = {div_r[g].dq_y[QB-2:0], 1'b0};
      if (tx >= {1'b0, div_r[g].dv}) begin
        div_nxt.rem_x   = DVW'(tx - {1'b0, div_r[g].dv});
        div_nxt.dq_x[0] = 1'b1;
      end else begin
        div_nxt.rem_x   = tx[DVW-1:0];
      end
      if (ty >= {1'b0, div_r[g].dv}) begin
        div_nxt.rem_y   = DVW'(ty - {1'b0, div_r[g].dv});
        div_nxt.dq_y[0] = 1'b1;
      end else begin
        div_nxt.rem_y   = ty[DVW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[g+1] <= div_nxt;
      end
    end
  end

  // ---------------- g1: clip centers, center minus point A
  function automatic logic [OW:0] clip_q(input logic neg, input logic ovf,
                                         input logic [QB-1:0] q);
    logic          sat;
    logic [OW-1:0] val;
    if (neg) begin
      sat = ovf || (q > NEG_MAX);
      val = sat ? 32'h8000_0000 : (~q[OW-1:0] + 32'd1);
    end else begin
      sat = ovf || (q > POS_MAX);
      val = sat ? 32'h7FFF_FFFF : q[OW-1:0];
    end
    return {sat, val};
  endfunction

  function automatic logic signed [CW-1:0] gap_d(input logic neg, input logic [QB-1:0] q,
                                                 input logic signed [CB-1:0] p);
    logic signed [CW-1:0] cq;
    cq = $signed(CW'(q));
    if (neg) begin
      cq = -cq;
    end
    return cq - (CW'(p) <<< FB);
  endfunction

  div_t                 dq;
  logic [OW:0]          clx, cly;
  logic                 g1_v_r, g1_satc_r, g1_coll_r, g1_ok_r;
  logic [OW-1:0]        g1_cx_r, g1_cy_r;
  logic signed [CW-1:0] g1_dx_r, g1_dy_r;

  assign dq  = div_r[QB];
  assign clx = clip_q(dq.neg_x, dq.ovf_x, dq.dq_x);
  assign cly = clip_q(dq.neg_y, dq.ovf_y, dq.dq_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
    end else if (adv) begin
      g1_v_r <= dvv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_cx_r   <= clx[OW-1:0];
      g1_cy_r   <= cly[OW-1:0];
      g1_satc_r <= clx[OW] || cly[OW];
      g1_coll_r <= dq.coll;
      // a quotient of 2^40 or more puts the center too far for any radius
      g1_ok_r   <= !dq.ovf_x && !dq.dq_x[QB-1] && !dq.ovf_y && !dq.dq_y[QB-1];
      g1_dx_r   <= gap_d(dq.neg_x, dq.dq_x, dq.ax);
      g1_dy_r   <= gap_d(dq.neg_y, dq.dq_y, dq.ay);
    end
  end

  // ---------------- g2: gap magnitudes
  logic            g2_v_r, g2_satc_r, g2_coll_r, g2_ok_r;
  logic [OW-1:0]   g2_cx_r, g2_cy_r, g2_ux_r, g2_uy_r;
  logic [CW-1:0]   gx, gy;

  assign gx = g1_dx_r[CW-1] ? CW'(-g1_dx_r) : CW'(g1_dx_r);
  assign gy = g1_dy_r[CW-1] ? CW'(-g1_dy_r) : CW'(g1_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_v_r <= 1'b0;
    end else if (adv) begin
      g2_v_r <= g1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_cx_r   <= g1_cx_r;
      g2_cy_r   <= g1_cy_r;
      g2_satc_r <= g1_satc_r;
      g2_coll_r <= g1_coll_r;
      g2_ok_r   <= g1_ok_r && (gx[CW-1:OW] == '0) && (gy[CW-1:OW] == '0);
      g2_ux_r   <= gx[OW-1:0];
      g2_uy_r   <= gy[OW-1:0];
    end
  end

  // ---------------- g3: squared gaps
  logic            g3_v_r, g3_satc_r, g3_coll_r, g3_ok_r;
  logic [OW-1:0]   g3_cx_r, g3_cy_r;
  logic [RW-1:0]   g3_sx_r, g3_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g3_v_r <= 1'b0;
    end else if (adv) begin
      g3_v_r <= g2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g3_cx_r   <= g2_cx_r;
      g3_cy_r   <= g2_cy_r;
      g3_satc_r <= g2_satc_r;
      g3_coll_r <= g2_coll_r;
      g3_ok_r   <= g2_ok_r;
      g3_sx_r   <= RW'(g2_ux_r) * RW'(g2_ux_r);
      g3_sy_r   <= RW'(g2_uy_r) * RW'(g2_uy_r);
    end
  end

  // ---------------- square root: sum, then two operand bits per stage
  sqrt_t         sq_r [0:SQN];
  logic [SQN:0]  sqv_r;
  logic [RW:0]   dsum;

  assign dsum = {1'b0, g3_sx_r} + {1'b0, g3_sy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r <= '0;
    end else if (adv) begin
      sqv_r <= {sqv_r[SQN-1:0], g3_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].v    <= dsum[RW-1:0];
      sq_r[0].r    <= '0;
      sq_r[0].cx   <= g3_cx_r;
      sq_r[0].cy   <= g3_cy_r;
      sq_r[0].satc <= g3_satc_r;
      sq_r[0].coll <= g3_coll_r;
      sq_r[0].rsat <= !g3_ok_r || dsum[RW];
    end
  end

  for (genvar g = 0; g < SQN; g++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * g);
    logic [RW-1:0] trial;
    sqrt_t         sq_nxt;

    always_comb begin
      sq_nxt = sq_r[g];
      trial  = sq_r[g].r + BIT;
      if (sq_r[g].v >= trial) begin
        sq_nxt.v = sq_r[g].v - trial;
        sq_nxt.r = (sq_r[g].r >> 1) + BIT;
      end else begin
        sq_nxt.r = sq_r[g].r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[g+1] <= sq_nxt;
      end
    end
  end

  // ---------------- output register: round the root, apply flags
  sqrt_t             sf;
  logic [RW-1:0]     rad;
  logic              rsat_f;
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;
  logic [USR_W-1:0]  out_tuser_r;
  logic [USR_W-1:0]  out_tuser_nxt;

  assign sf     = sq_r[SQN];
  // remainder above the root means the exact root is past the half point
  assign rad    = (sf.v > sf.r) ? sf.r + RW'(1) : sf.r;
  assign rsat_f = sf.rsat || (rad[RW-1:OW] != '0);

  always_comb begin
    out_tuser_nxt = '0;
    if (sf.coll) begin
      out_tuser_nxt[USR_COLL] = 1'b1;
    end else begin
      out_tuser_nxt[USR_SAT] = sf.satc || rsat_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= sqv_r[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tuser_r <= out_tuser_nxt;
      if (sf.coll) begin
        out_tdata_r <= '0;
      end else begin
        out_tdata_r <= {(rsat_f ? 32'hFFFF_FFFF : rad[OW-1:0]), sf.cy, sf.cx};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- assertions
  a_coll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USR_COLL] |-> (out_tdata == '0) && !out_tuser[USR_SAT])
    else $error("collinear word with nonzero payload or saturation");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(dvv_r) && $stable(sqv_r))
    else $error("pipeline valid bits moved during a stall");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dvv_r[QB] && !dq.coll && (dq.ovf_x || dq.ovf_y) |=> g1_satc_r && !g1_ok_r)
    else $error("divider overflow not flagged as saturation");

endmodule

`default_nettype wire
